// ----- hw/rtl/a2g_pkg.sv -----
// shared types, constants and the character map of the ascii to game charset encoder
package a2g_pkg;

    // defaults for the top level parameters
    localparam int INDEX_BITS_DEF = 16;

    // fixed field widths
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 16;
    localparam int CODE_W = 8;
    localparam int COL_W  = 16;
    localparam int CAP_W  = 16;
    localparam int WRAP_W = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_COLUMNS  = 1'b1;

    // configuration reset values
    localparam logic [CAP_W-1:0]  CAPACITY_RST = 16'd256;
    localparam logic [WRAP_W-1:0] WRAP_RST     = 8'd34;

    // ascii codes with special handling
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_EXCL  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DQUOT = 8'h22;
    localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DOLL  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

    // game charset codes
    localparam logic [CODE_W-1:0] GC_BLANK       = 8'h00;
    localparam logic [CODE_W-1:0] GC_NUM_BASE    = 8'hA1;
    localparam logic [CODE_W-1:0] GC_UC_BASE     = 8'hBB;
    localparam logic [CODE_W-1:0] GC_LC_BASE     = 8'hD5;
    localparam logic [CODE_W-1:0] GC_EXCL        = 8'hAB;
    localparam logic [CODE_W-1:0] GC_QUEST       = 8'hAC;
    localparam logic [CODE_W-1:0] GC_DOT         = 8'hAD;
    localparam logic [CODE_W-1:0] GC_DASH        = 8'hAE;
    localparam logic [CODE_W-1:0] GC_DQUOT       = 8'hB2;
    localparam logic [CODE_W-1:0] GC_APOS        = 8'hB4;
    localparam logic [CODE_W-1:0] GC_DOLL        = 8'hB7;
    localparam logic [CODE_W-1:0] GC_PAUSE_MARK  = 8'hB8;
    localparam logic [CODE_W-1:0] GC_STROKE      = 8'hBA;
    localparam logic [CODE_W-1:0] GC_TWO_DOT     = 8'hF0;
    localparam logic [CODE_W-1:0] GC_LPAR        = 8'h5C;
    localparam logic [CODE_W-1:0] GC_RPAR        = 8'h5D;
    localparam logic [CODE_W-1:0] GC_BREAK_FIRST = 8'hFE;
    localparam logic [CODE_W-1:0] GC_BREAK_LATER = 8'hFA;
    localparam logic [CODE_W-1:0] GC_NONE        = 8'hFF;
    localparam logic [CODE_W-1:0] GC_END         = 8'hFF;

    // one output result
    typedef struct packed {
        logic [IDX_W-1:0]  write_index;
        logic [CODE_W-1:0] code;
        logic              run_last;
        logic              end_of_text;
    } result_t;

    // ascii to game charset, GC_NONE for anything without an entry
    function automatic logic [CODE_W-1:0] map_char(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] c;
        c = GC_NONE;
        case (ch) inside
            [CH_ZERO:CH_NINE]: c = GC_NUM_BASE + (ch - CH_ZERO);
            [CH_UC_A:CH_UC_Z]: c = GC_UC_BASE + (ch - CH_UC_A);
            [CH_LC_A:CH_LC_Z]: c = GC_LC_BASE + (ch - CH_LC_A);
            CH_EXCL:           c = GC_EXCL;
            CH_QUEST:          c = GC_QUEST;
            CH_DOT:            c = GC_DOT;
            CH_DASH:           c = GC_DASH;
            CH_DQUOT:          c = GC_DQUOT;
            CH_APOS:           c = GC_APOS;
            CH_DOLL:           c = GC_DOLL;
            CH_COMMA, CH_SEMI: c = GC_PAUSE_MARK;
            CH_SLASH:          c = GC_STROKE;
            CH_COLON:          c = GC_TWO_DOT;
            CH_LPAR:           c = GC_LPAR;
            CH_RPAR:           c = GC_RPAR;
            default:           c = GC_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/ascii_to_game_charset_wrapper.sv -----
// top level of the ascii to game charset encoder with stream ports and config port
//
// channel  | signals                        | payload
// ---------+--------------------------------+-------------------------------------------
// s        | s_tvalid s_tready s_tdata      | ascii_char [7:0]
// m        | m_tvalid m_tready m_tdata      | write_index [15:0], code [23:16]
//          | m_tlast m_tuser                | tlast = run_last, tuser = end_of_text
// cfg      | cfg_we cfg_index cfg_data      | 0 dest_capacity [15:0], 1 wrap_columns [7:0]
//
// one byte per cycle while m_tready is high and no wrap is pending: a byte is taken into
// the input register, then encoded, and its first result lands in the output register
// a line wrap adds a second result held in a pending register; the input stage
// waits while that result drains into the output register
// reset clears the line state and loads capacity 256 and wrap limit 34
// m_tready low stalls the output register and, through it, the input register
module ascii_to_game_charset_wrapper #(
    parameter int INDEX_BITS = a2g_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // ascii_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,    // write_index, code
    output logic                          m_tlast,    // run_last
    output logic                          m_tuser,    // end_of_text
    input  logic                          cfg_we,
    input  logic [a2g_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [a2g_pkg::CAP_W-1:0]     cfg_data
);

    // configuration
    logic [a2g_pkg::CAP_W-1:0]  capacity_reg;
    logic [a2g_pkg::WRAP_W-1:0] wrap_reg;

    // input register
    logic                       in_valid_reg;
    logic [a2g_pkg::CHAR_W-1:0] in_char_reg;

    // line state
    logic [INDEX_BITS-1:0]      write_pos_reg;
    logic [a2g_pkg::COL_W-1:0]  column_reg;
    logic                       wrapped_once_reg;
    logic [INDEX_BITS-1:0]      space_pos_reg;
    logic                       space_valid_reg;

    logic [INDEX_BITS-1:0]      write_pos_next;
    logic [a2g_pkg::COL_W-1:0]  column_next;
    logic                       wrapped_once_next;
    logic [INDEX_BITS-1:0]      space_pos_next;
    logic                       space_valid_next;

    // output register and the pending wrap result behind it
    logic                       out_valid_reg;
    a2g_pkg::result_t           out_res_reg;
    logic                       pend_valid_reg;
    a2g_pkg::result_t           pend_res_reg;

    a2g_pkg::result_t           res0;
    a2g_pkg::result_t           res1;
    logic                       res0_valid;
    logic                       res1_valid;

    logic                       out_free;
    logic                       consume;

    a2g_encode #(
        .INDEX_BITS (INDEX_BITS)
    ) u_encode (
        .ascii_char        (in_char_reg),
        .dest_capacity     (capacity_reg),
        .wrap_columns      (wrap_reg),
        .write_pos         (write_pos_reg),
        .column            (column_reg),
        .wrapped_once      (wrapped_once_reg),
        .space_pos         (space_pos_reg),
        .space_valid       (space_valid_reg),
        .res0              (res0),
        .res0_valid        (res0_valid),
        .res1              (res1),
        .res1_valid        (res1_valid),
        .write_pos_next    (write_pos_next),
        .column_next       (column_next),
        .wrapped_once_next (wrapped_once_next),
        .space_pos_next    (space_pos_next),
        .space_valid_next  (space_valid_next)
    );

    // the output register can load this cycle
    assign out_free = !out_valid_reg || m_tready;
    // the byte in the input register is encoded this cycle
    assign consume  = in_valid_reg && out_free && !pend_valid_reg;
    assign s_tready = !in_valid_reg || consume;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.code, out_res_reg.write_index};
    assign m_tlast  = out_res_reg.run_last;
    assign m_tuser  = out_res_reg.end_of_text;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= a2g_pkg::CAPACITY_RST;
            wrap_reg     <= a2g_pkg::WRAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                a2g_pkg::REG_DEST_CAPACITY: capacity_reg <= cfg_data;
                a2g_pkg::REG_WRAP_COLUMNS:  wrap_reg     <= cfg_data[a2g_pkg::WRAP_W-1:0];
                default:                    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
    end

    // line state advances once per encoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg    <= '0;
            column_reg       <= '0;
            wrapped_once_reg <= 1'b0;
            space_pos_reg    <= '0;
            space_valid_reg  <= 1'b0;
        end
        else if (consume)
        begin
            write_pos_reg    <= write_pos_next;
            column_reg       <= column_next;
            wrapped_once_reg <= wrapped_once_next;
            space_pos_reg    <= space_pos_next;
            space_valid_reg  <= space_valid_next;
        end
    end

    // output valid flags: pending result goes out first, then fresh results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= consume && res0_valid;
                pend_valid_reg <= consume && res1_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_res_reg <= pend_res_reg;
            end
            else if (consume)
            begin
                out_res_reg  <= res0;
                pend_res_reg <= res1;
            end
        end
    end

    // a pending wrap result always sits behind a loaded output register
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without output result");

    // the result ahead of a pending wrap is never the last of its byte
    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !out_res_reg.run_last)
        else $error("first result of a wrap marked last");

    // terminator clears the line state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_char_reg == a2g_pkg::CH_NUL) |=>
            (write_pos_reg == '0 && !space_valid_reg && !wrapped_once_reg))
        else $error("line state not cleared after terminator");

    // line state only moves when a byte is encoded
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !consume |=> ($stable(write_pos_reg) && $stable(column_reg)))
        else $error("line state changed without an encoded byte");

endmodule

// ----- hw/rtl/a2g_encode.sv -----
// per-character encode logic: results and next line state from one byte
module a2g_encode #(
    parameter int INDEX_BITS = a2g_pkg::INDEX_BITS_DEF
) (
    input  logic [a2g_pkg::CHAR_W-1:0] ascii_char,
    input  logic [a2g_pkg::CAP_W-1:0]  dest_capacity,
    input  logic [a2g_pkg::WRAP_W-1:0] wrap_columns,
    input  logic [INDEX_BITS-1:0]      write_pos,
    input  logic [a2g_pkg::COL_W-1:0]  column,
    input  logic                       wrapped_once,
    input  logic [INDEX_BITS-1:0]      space_pos,
    input  logic                       space_valid,
    output a2g_pkg::result_t           res0,
    output logic                       res0_valid,
    output a2g_pkg::result_t           res1,
    output logic                       res1_valid,
    output logic [INDEX_BITS-1:0]      write_pos_next,
    output logic [a2g_pkg::COL_W-1:0]  column_next,
    output logic                       wrapped_once_next,
    output logic [INDEX_BITS-1:0]      space_pos_next,
    output logic                       space_valid_next
);

    localparam int WIDE = (INDEX_BITS > a2g_pkg::IDX_W) ? INDEX_BITS : a2g_pkg::IDX_W;

    function automatic logic [a2g_pkg::IDX_W-1:0] to_index(input logic [INDEX_BITS-1:0] p);
        logic [WIDE-1:0] w;
        w = WIDE'(p);
        return w[a2g_pkg::IDX_W-1:0];
    endfunction

    logic                        is_nul;
    logic                        is_space;
    logic                        full;
    logic                        emit;
    logic                        wrap;
    logic [a2g_pkg::CHAR_W-1:0]  ch_n;
    logic [a2g_pkg::CODE_W-1:0]  mapped;
    logic [a2g_pkg::CODE_W-1:0]  code0;
    logic [WIDE:0]               room_sum;
    logic [INDEX_BITS-1:0]       sp_pos_n;
    logic                        sp_valid_n;
    logic [INDEX_BITS-1:0]       wpos_inc;
    logic [INDEX_BITS-1:0]       gap;
    logic [a2g_pkg::COL_W-1:0]   col_inc;

    always_comb
    begin
        is_nul = (ascii_char == a2g_pkg::CH_NUL);
        // whitespace folds to space
        if (ascii_char == a2g_pkg::CH_LF || ascii_char == a2g_pkg::CH_CR ||
            ascii_char == a2g_pkg::CH_TAB)
        begin
            ch_n = a2g_pkg::CH_SPACE;
        end
        else
        begin
            ch_n = ascii_char;
        end
        is_space = (ch_n == a2g_pkg::CH_SPACE);
        // high bytes have no map entry
        mapped   = a2g_pkg::map_char(ch_n);
        code0    = is_space ? a2g_pkg::GC_BLANK : mapped;

        room_sum = (WIDE+1)'(write_pos) + (WIDE+1)'(2);
        full     = (room_sum >= (WIDE+1)'(dest_capacity));

        emit = !is_nul && !full &&
               (is_space ? (column != '0) : (mapped != a2g_pkg::GC_NONE));

        sp_pos_n   = is_space ? write_pos : space_pos;
        sp_valid_n = is_space || space_valid;
        wpos_inc   = write_pos + INDEX_BITS'(1);
        col_inc    = (column == '1) ? column : column + a2g_pkg::COL_W'(1);
        wrap       = (col_inc >= a2g_pkg::COL_W'(wrap_columns)) && sp_valid_n;
        gap        = wpos_inc - sp_pos_n - INDEX_BITS'(1);

        // result for the byte itself, or the terminator
        res0.write_index = to_index(write_pos);
        res0.code        = is_nul ? a2g_pkg::GC_END : code0;
        res0.run_last    = !(emit && wrap);
        res0.end_of_text = is_nul;
        res0_valid       = is_nul || emit;

        // line break rewrite of the last space
        res1.write_index = to_index(sp_pos_n);
        res1.code        = wrapped_once ? a2g_pkg::GC_BREAK_LATER : a2g_pkg::GC_BREAK_FIRST;
        res1.run_last    = 1'b1;
        res1.end_of_text = 1'b0;
        res1_valid       = emit && wrap;

        write_pos_next    = write_pos;
        column_next       = column;
        wrapped_once_next = wrapped_once;
        space_pos_next    = space_pos;
        space_valid_next  = space_valid;
        if (is_nul)
        begin
            write_pos_next    = '0;
            column_next       = '0;
            wrapped_once_next = 1'b0;
            space_pos_next    = '0;
            space_valid_next  = 1'b0;
        end
        else if (emit)
        begin
            write_pos_next    = wpos_inc;
            column_next       = wrap ? to_index(gap) : col_inc;
            wrapped_once_next = wrapped_once || wrap;
            space_pos_next    = sp_pos_n;
            space_valid_next  = sp_valid_n && !wrap;
        end
    end

endmodule

// ----- bench/tb_ascii_to_game_charset_wrapper.sv -----
// testbench for the ascii to game charset encoder: random text streams checked against a predictor
`timescale 1ns / 1ps

module tb_ascii_to_game_charset_wrapper;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // cycles to let the pipeline settle once nothing is expected
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES = 11;

    // tracks the encoder line state and holds the buffer writes still due
    class charset_scoreboard;
        logic [a2g_pkg::CAP_W-1:0]  capacity;
        logic [a2g_pkg::WRAP_W-1:0] wrap_limit;
        int unsigned                pos;
        int unsigned                col;
        int unsigned                space_at;
        bit                         space_seen;
        bit                         broke_once;
        a2g_pkg::result_t           writes_due[$];
        int                         errors;

        function new();
            capacity   = a2g_pkg::CAPACITY_RST;
            wrap_limit = a2g_pkg::WRAP_RST;
            errors     = 0;
            clear_line();
        endfunction

        function void clear_line();
            pos        = 0;
            col        = 0;
            space_at   = 0;
            space_seen = 0;
            broke_once = 0;
        endfunction

        function void set_reg(logic [a2g_pkg::CFG_IDX_W-1:0] idx,
                              logic [a2g_pkg::CAP_W-1:0] data);
            if (idx == a2g_pkg::REG_DEST_CAPACITY)
                capacity = data;
            else
                wrap_limit = data[a2g_pkg::WRAP_W-1:0];
        endfunction

        // game charset code of a printable character, GC_NONE when unmapped
        function logic [a2g_pkg::CODE_W-1:0] game_code(logic [a2g_pkg::CHAR_W-1:0] ch);
            logic [a2g_pkg::CODE_W-1:0] c;
            c = a2g_pkg::GC_NONE;
            if (ch >= a2g_pkg::CH_ZERO && ch <= a2g_pkg::CH_NINE)
                c = a2g_pkg::GC_NUM_BASE + (ch - a2g_pkg::CH_ZERO);
            else if (ch >= a2g_pkg::CH_UC_A && ch <= a2g_pkg::CH_UC_Z)
                c = a2g_pkg::GC_UC_BASE + (ch - a2g_pkg::CH_UC_A);
            else if (ch >= a2g_pkg::CH_LC_A && ch <= a2g_pkg::CH_LC_Z)
                c = a2g_pkg::GC_LC_BASE + (ch - a2g_pkg::CH_LC_A);
            else if (ch == a2g_pkg::CH_EXCL)  c = a2g_pkg::GC_EXCL;
            else if (ch == a2g_pkg::CH_QUEST) c = a2g_pkg::GC_QUEST;
            else if (ch == a2g_pkg::CH_DOT)   c = a2g_pkg::GC_DOT;
            else if (ch == a2g_pkg::CH_DASH)  c = a2g_pkg::GC_DASH;
            else if (ch == a2g_pkg::CH_DQUOT) c = a2g_pkg::GC_DQUOT;
            else if (ch == a2g_pkg::CH_APOS)  c = a2g_pkg::GC_APOS;
            else if (ch == a2g_pkg::CH_DOLL)  c = a2g_pkg::GC_DOLL;
            else if (ch == a2g_pkg::CH_COMMA || ch == a2g_pkg::CH_SEMI)
                c = a2g_pkg::GC_PAUSE_MARK;
            else if (ch == a2g_pkg::CH_SLASH) c = a2g_pkg::GC_STROKE;
            else if (ch == a2g_pkg::CH_COLON) c = a2g_pkg::GC_TWO_DOT;
            else if (ch == a2g_pkg::CH_LPAR)  c = a2g_pkg::GC_LPAR;
            else if (ch == a2g_pkg::CH_RPAR)  c = a2g_pkg::GC_RPAR;
            return c;
        endfunction

        // note an accepted byte and queue the writes it causes
        function void take_char(logic [a2g_pkg::CHAR_W-1:0] ch);
            logic [a2g_pkg::CHAR_W-1:0] c;
            logic [a2g_pkg::CODE_W-1:0] code;
            a2g_pkg::result_t           w;
            a2g_pkg::result_t           brk;
            bit                         wrap_now;
            c = ch;
            if (c == a2g_pkg::CH_NUL)
            begin
                w.write_index = pos[a2g_pkg::IDX_W-1:0];
                w.code        = a2g_pkg::GC_END;
                w.run_last    = 1'b1;
                w.end_of_text = 1'b1;
                writes_due.push_back(w);
                clear_line();
                return;
            end
            if (pos + 2 >= capacity)
                return;
            if (c == a2g_pkg::CH_LF || c == a2g_pkg::CH_CR || c == a2g_pkg::CH_TAB)
                c = a2g_pkg::CH_SPACE;
            if (c[7])
                return;
            if (c == a2g_pkg::CH_SPACE)
            begin
                if (col == 0)
                    return;
                code       = a2g_pkg::GC_BLANK;
                space_at   = pos;
                space_seen = 1;
            end
            else
            begin
                code = game_code(c);
                if (code == a2g_pkg::GC_NONE)
                    return;
            end
            w.write_index = pos[a2g_pkg::IDX_W-1:0];
            w.code        = code;
            w.end_of_text = 1'b0;
            pos = (pos + 1) & 32'hFFFF;
            if (col < 32'hFFFF)
                col++;
            wrap_now   = (col >= wrap_limit) && space_seen;
            w.run_last = !wrap_now;
            writes_due.push_back(w);
            if (wrap_now)
            begin
                brk.write_index = space_at[a2g_pkg::IDX_W-1:0];
                brk.code        = broke_once ? a2g_pkg::GC_BREAK_LATER
                                             : a2g_pkg::GC_BREAK_FIRST;
                brk.run_last    = 1'b1;
                brk.end_of_text = 1'b0;
                writes_due.push_back(brk);
                col        = (pos - space_at - 1) & 32'hFFFF;
                space_seen = 0;
                broke_once = 1;
            end
        endfunction

        // compare one buffer write from the block with the oldest one due
        function void check_write(a2g_pkg::result_t got);
            a2g_pkg::result_t want;
            if (writes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("error: unexpected write index %0d code %h last %b eot %b",
                             got.write_index, got.code, got.run_last, got.end_of_text);
                return;
            end
            want = writes_due.pop_front();
            if (got.write_index !== want.write_index || got.code !== want.code ||
                got.run_last !== want.run_last || got.end_of_text !== want.end_of_text)
            begin
                errors++;
                if (errors <= 10)
                    $display({"error: write expected idx %0d code %h last %b eot %b, ",
                              "got idx %0d code %h last %b eot %b"},
                             want.write_index, want.code, want.run_last, want.end_of_text,
                             got.write_index, got.code, got.run_last, got.end_of_text);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;    // ascii_char
    logic                          m_tvalid;
    logic                          m_tready;
    logic [23:0]                   m_tdata;    // write_index [15:0], code [23:16]
    logic                          m_tlast;    // run_last
    logic                          m_tuser;    // end_of_text
    logic                          cfg_we;
    logic [a2g_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [a2g_pkg::CAP_W-1:0]     cfg_data;

    charset_scoreboard sb;
    // random gaps on both sides while set, back-to-back transfers while clear
    bit gaps_on;
    int quiet_cycles;

    ascii_to_game_charset_wrapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // one byte per transfer; tvalid stays high across back-to-back bytes
    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_char(ch);
    endtask

    // stop sending and wait until every write due has come out
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (sb.writes_due.size() != 0)
            @(posedge clk);
        // bytes that cause no write may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [a2g_pkg::CFG_IDX_W-1:0] idx,
                             input logic [a2g_pkg::CAP_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    function automatic logic [7:0] punct_char(int k);
        case (k)
            0:       return a2g_pkg::CH_EXCL;
            1:       return a2g_pkg::CH_QUEST;
            2:       return a2g_pkg::CH_DOT;
            3:       return a2g_pkg::CH_DASH;
            4:       return a2g_pkg::CH_DQUOT;
            5:       return a2g_pkg::CH_APOS;
            6:       return a2g_pkg::CH_DOLL;
            7:       return a2g_pkg::CH_COMMA;
            8:       return a2g_pkg::CH_SEMI;
            9:       return a2g_pkg::CH_SLASH;
            10:      return a2g_pkg::CH_COLON;
            11:      return a2g_pkg::CH_LPAR;
            default: return a2g_pkg::CH_RPAR;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return a2g_pkg::CH_LC_A + 8'($urandom_range(0, 25));
        else if (r < 6)
            return a2g_pkg::CH_UC_A + 8'($urandom_range(0, 25));
        else if (r < 7)
            return a2g_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        return punct_char($urandom_range(0, 12));
    endfunction

    // whitespace, plain space half of the time
    function automatic logic [7:0] gap_char();
        case ($urandom_range(0, 5))
            0:       return a2g_pkg::CH_TAB;
            1:       return a2g_pkg::CH_LF;
            2:       return a2g_pkg::CH_CR;
            default: return a2g_pkg::CH_SPACE;
        endcase
    endfunction

    // words split by whitespace with a little noise, closed by the end byte
    task automatic send_text(input int budget);
        int sent;
        int wlen;
        sent = 0;
        while (sent < budget)
        begin
            // runs of whitespace exercise leading-space dropping
            if ($urandom_range(0, 3) == 0)
                send_char(gap_char());
            wlen = $urandom_range(1, 7);
            repeat (wlen) send_char(word_char());
            send_char(gap_char());
            sent += wlen + 1;
            // a random nonzero byte as noise: unmapped and high bytes must vanish without a write
            if ($urandom_range(0, 9) == 0)
                send_char(8'($urandom_range(1, 255)));
        end
        send_char(a2g_pkg::CH_NUL);
    endtask

    // result side: random tready stalls, every transfer checked in order
    initial
    begin : result_side
        int               stall;
        a2g_pkg::result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            got.write_index = m_tdata[15:0];
            got.code        = m_tdata[23:16];
            got.run_last    = m_tlast;
            got.end_of_text = m_tuser;
            sb.check_write(got);
        end
    end

    // watchdog: any transfer on either side counts as progress
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [a2g_pkg::CAP_W-1:0]  caps  [NUM_PHASES];
        logic [a2g_pkg::WRAP_W-1:0] wraps [NUM_PHASES];
        logic [7:0]                 directed [$];

        sb           = new();
        gaps_on      = 1'b1;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = a2g_pkg::REG_DEST_CAPACITY;
        cfg_data     = '0;

        // capacity and wrap settings, extremes included: tiny buffers that
        // only ever hold the terminator, a zero wrap limit, full-range values
        caps  = '{16'd65535, 16'd1, 16'd2, 16'd0, 16'd60, 16'd3,
                  16'd40, 16'd20, 16'd100, 16'd65535, 16'd12};
        wraps = '{8'd255, 8'd1, 8'd1, 8'd5, 8'd0, 8'd1,
                  8'd6, 8'd4, 8'd12, 8'd1, 8'd3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text at reset settings: leading space and tab dropped,
        // digit and letter extremes, every punctuation mark, an unmapped
        // character, high bytes, then the end byte
        directed = '{a2g_pkg::CH_SPACE, a2g_pkg::CH_TAB, 8'h69, a2g_pkg::CH_SPACE,
                     a2g_pkg::CH_ZERO, a2g_pkg::CH_NINE, a2g_pkg::CH_SEMI,
                     a2g_pkg::CH_UC_A, a2g_pkg::CH_LC_Z, a2g_pkg::CH_EXCL,
                     a2g_pkg::CH_QUEST, a2g_pkg::CH_DOT, a2g_pkg::CH_DASH,
                     a2g_pkg::CH_DQUOT, a2g_pkg::CH_APOS, a2g_pkg::CH_DOLL,
                     a2g_pkg::CH_COMMA, a2g_pkg::CH_SLASH, a2g_pkg::CH_COLON,
                     a2g_pkg::CH_LPAR, a2g_pkg::CH_RPAR,
                     8'h7E, 8'h80, 8'hFF, a2g_pkg::CH_NUL};
        foreach (directed[i])
            send_char(directed[i]);
        drain_writes();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(a2g_pkg::REG_DEST_CAPACITY, caps[p]);
            write_reg(a2g_pkg::REG_WRAP_COLUMNS,
                      {{(a2g_pkg::CAP_W-a2g_pkg::WRAP_W){1'b0}}, wraps[p]});
            // every third phase runs back to back on both sides
            gaps_on = (p % 3) != 2;
            send_text($urandom_range(8, 20));
            // in phase 6, hold the sender off mid-phase until the block has caught up
            if (p == 6)
            begin
                s_tvalid <= 1'b0;
                while (sb.writes_due.size() != 0)
                    @(posedge clk);
            end
            send_text($urandom_range(8, 20));
            drain_writes();
        end

        repeat (4) @(posedge clk);
        if (sb.writes_due.size() != 0)
        begin
            sb.errors++;
            $display("error: %0d writes never arrived", sb.writes_due.size());
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
